// ----- rtl/lsbpk_pkg.sv -----
// Package for the LSB-first bit packer with interleaved gamma writer.
// Holds the request types, opcodes, controller states and the command/status
// structs shared by the controller, the datapath and the top level.
package lsbpk_pkg;

    // Default word size for the raw and gamma commands
    localparam int WORD_BITS_DEF = 64;

    // Opcodes of the input request
    localparam logic [1:0] OP_RAW    = 2'd0;
    localparam logic [1:0] OP_GAMMA  = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    // Input request payload
    typedef struct packed {
        logic [1:0]  opcode;
        logic [6:0]  width;
        logic [63:0] value;
    } in_req_t;

    // Output request payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } out_req_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NORM,
        ST_SEND,
        ST_FLUSH
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_raw;
        logic load_gamma;
        logic shift_byte;
        logic shift_bit;
        logic step;
        logic flush;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic raw_empty;
        logic val_zero;
        logic pend_any;
        logic top_byte_zero;
        logic top_bit_zero;
        logic step_done;
        logic slot_free;
    } stat_t;

endpackage

// ----- rtl/lsbpk_ctrl.sv -----
// Controller of the bit packer: sequences load, normalize, send and flush.
// Depends on lsbpk_pkg for the state, command and status types.
module lsbpk_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [1:0]         opcode,
    output logic               in_ready,
    input  lsbpk_pkg::stat_t   st,
    output lsbpk_pkg::cmd_t    cmd
);

    lsbpk_pkg::state_t state_reg;
    lsbpk_pkg::state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsbpk_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decide next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            lsbpk_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (opcode)
                        lsbpk_pkg::OP_RAW:
                        begin
                            cmd.load_raw = 1'b1;
                            state_next   = st.raw_empty ? lsbpk_pkg::ST_IDLE
                                                        : lsbpk_pkg::ST_SEND;
                        end
                        lsbpk_pkg::OP_GAMMA:
                        begin
                            cmd.load_gamma = 1'b1;
                            state_next     = st.val_zero ? lsbpk_pkg::ST_SEND
                                                         : lsbpk_pkg::ST_NORM;
                        end
                        lsbpk_pkg::OP_FINISH:
                        begin
                            state_next = st.pend_any ? lsbpk_pkg::ST_FLUSH
                                                     : lsbpk_pkg::ST_IDLE;
                        end
                        default:
                        begin
                            state_next = lsbpk_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            lsbpk_pkg::ST_NORM:
            begin
                // Bring the leading one to the top: bytes first, then bits
                if (st.top_byte_zero)
                begin
                    cmd.shift_byte = 1'b1;
                end
                else if (st.top_bit_zero)
                begin
                    cmd.shift_bit = 1'b1;
                end
                else
                begin
                    state_next = lsbpk_pkg::ST_SEND;
                end
            end
            lsbpk_pkg::ST_SEND:
            begin
                if (st.slot_free)
                begin
                    cmd.step = 1'b1;
                    if (st.step_done)
                    begin
                        state_next = lsbpk_pkg::ST_IDLE;
                    end
                end
            end
            lsbpk_pkg::ST_FLUSH:
            begin
                if (st.slot_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = lsbpk_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lsbpk_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // A flush always returns to idle
    a_flush_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |=> state_reg == lsbpk_pkg::ST_IDLE)
        else $error("flush did not return to idle");

    // Normalizing stops once the leading one is at the top
    a_norm_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lsbpk_pkg::ST_NORM) && !st.top_byte_zero && !st.top_bit_zero
        |=> state_reg == lsbpk_pkg::ST_SEND)
        else $error("normalize did not hand over to send");

    // At most one datapath command per cycle
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command");
`endif

endmodule

// ----- rtl/lsbpk_dp.sv -----
// Datapath of the bit packer: source shift register, pending bits and the
// output byte register. Depends on lsbpk_pkg for types and commands.
module lsbpk_dp #(
    parameter int WORD_BITS = lsbpk_pkg::WORD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lsbpk_pkg::in_req_t  in_data,
    input  lsbpk_pkg::cmd_t     cmd,
    output lsbpk_pkg::stat_t    st,
    output logic                out_valid,
    input  logic                out_ready,
    output lsbpk_pkg::out_req_t out_data
);

    localparam int CW = $clog2(WORD_BITS + 1);

    logic [6:0]           acc_reg, acc_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic [CW-1:0]        rem_reg, rem_next;
    logic [WORD_BITS-1:0] sh_reg, sh_next;
    logic                 gamma_reg, gamma_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    logic                 out_last_reg, out_last_next;

    logic [WORD_BITS-1:0] in_word;
    logic [CW-1:0]        width_clamped;
    logic [3:0]           take;
    logic [7:0]           chunk_raw;
    logic [7:0]           chunk;
    logic [3:0]           ccount;
    logic [7:0]           mask;
    logic [CW-1:0]        rem_after;
    logic [CW:0]          src_after;
    logic [14:0]          merged;
    logic [3:0]           total;
    logic [CW+1:0]        tail;
    logic                 emit;
    logic                 last;
    logic                 slot_free;

    assign in_word       = in_data.value[WORD_BITS-1:0];
    assign width_clamped = (in_data.width > 7'(WORD_BITS)) ? CW'(WORD_BITS)
                                                           : in_data.width[CW-1:0];
    assign slot_free     = !out_valid_reg || out_ready;

    // Form one chunk of up to eight stream bits
    always_comb
    begin
        chunk_raw = '0;
        if (gamma_reg)
        begin
            take = (rem_reg >= CW'(4)) ? 4'd4 : 4'(rem_reg);
            // Data bit from the top, then its stop bit
            for (int j = 0; j < 4; j++)
            begin
                chunk_raw[2*j]   = sh_reg[WORD_BITS-1-j];
                chunk_raw[2*j+1] = (rem_reg == CW'(j + 1));
            end
            ccount = 4'({take, 1'b0});
        end
        else
        begin
            take      = (rem_reg >= CW'(8)) ? 4'd8 : 4'(rem_reg);
            chunk_raw = sh_reg[7:0];
            ccount    = take;
        end
        mask      = 8'((9'd1 << ccount) - 9'd1);
        chunk     = chunk_raw & mask;
        rem_after = rem_reg - CW'(take);
        src_after = gamma_reg ? {rem_after, 1'b0} : {1'b0, rem_after};
        merged    = {8'd0, acc_reg} | ({7'd0, chunk} << cnt_reg);
        total     = {1'b0, cnt_reg} + ccount;
        emit      = total[3];
        tail      = (CW+2)'(total[2:0]) + (CW+2)'(src_after);
        last      = tail < (CW+2)'(8);
    end

    // Status to the controller
    always_comb
    begin
        st.raw_empty     = (in_data.width == 7'd0);
        st.val_zero      = (in_word == '0);
        st.pend_any      = (cnt_reg != 3'd0);
        st.top_byte_zero = (sh_reg[WORD_BITS-1 -: 8] == 8'd0);
        st.top_bit_zero  = !sh_reg[WORD_BITS-1];
        st.step_done     = (rem_after == '0);
        st.slot_free     = slot_free;
    end

    // Next values of all registers
    always_comb
    begin
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        sh_next        = sh_reg;
        gamma_next     = gamma_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        if (cmd.load_raw)
        begin
            gamma_next = 1'b0;
            sh_next    = in_word;
            rem_next   = width_clamped;
        end
        else if (cmd.load_gamma)
        begin
            // Zero encodes as a single 0 bit: send it as a one-bit raw field
            if (in_word == '0)
            begin
                gamma_next = 1'b0;
                sh_next    = '0;
                rem_next   = CW'(1);
            end
            else
            begin
                gamma_next = 1'b1;
                sh_next    = in_word;
                rem_next   = CW'(WORD_BITS);
            end
        end
        else if (cmd.shift_byte)
        begin
            sh_next  = sh_reg << 8;
            rem_next = rem_reg - CW'(8);
        end
        else if (cmd.shift_bit)
        begin
            sh_next  = sh_reg << 1;
            rem_next = rem_reg - CW'(1);
        end
        else if (cmd.step)
        begin
            sh_next  = gamma_reg ? (sh_reg << 4) : (sh_reg >> 8);
            rem_next = rem_after;
            cnt_next = total[2:0];
            acc_next = emit ? merged[14:8] : merged[6:0];
            if (emit)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = merged[7:0];
                out_last_next  = last;
            end
        end
        else if (cmd.flush)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = {1'b0, acc_reg};
            out_last_next  = 1'b1;
            acc_next       = '0;
            cnt_next       = '0;
        end
    end

    // Control and pending state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            gamma_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            gamma_reg     <= gamma_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sh_reg       <= sh_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid          = out_valid_reg;
    assign out_data.out_byte  = out_byte_reg;
    assign out_data.last_byte = out_last_reg;

`ifndef SYNTHESIS
    // Never advance into an occupied output register
    a_step_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step || cmd.flush) |-> slot_free)
        else $error("output register overwritten");

    // Flush only with bits pending, and it leaves none
    a_flush_pend: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |-> cnt_reg != 3'd0)
        else $error("flush with nothing pending");

    a_flush_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |=> (cnt_reg == 3'd0) && out_valid_reg && out_last_reg)
        else $error("flush did not produce a final byte");

    // Normalizing never runs on an empty word
    a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.shift_byte || cmd.shift_bit) |-> (sh_reg != '0) && gamma_reg)
        else $error("normalize on zero word");
`endif

endmodule

// ----- rtl/lsb_first_bit_packer_gamma_writer.sv -----
// LSB-first bit packer with interleaved gamma writer, top level.
// A completed byte is written into the output register by the step that completes it;
// a request is taken in idle only, in the cycle after the last step of the one before.
// Raw requests send up to 8 bits per step; gamma requests first normalize with up to 14
// byte and bit shifts, then send 4 data bits per step; zero sends one bit; finish flushes
// only with bits pending; a full output register stalls the steps.
// Reset (rst_n, async, low) clears pending bits, the controller and output valid.
module lsb_first_bit_packer_gamma_writer #(
    parameter int WORD_BITS = lsbpk_pkg::WORD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lsbpk_pkg::in_req_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output lsbpk_pkg::out_req_t out_data
);

    lsbpk_pkg::cmd_t  cmd;
    lsbpk_pkg::stat_t st;

    // Sequence the request
    lsbpk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (in_data.opcode),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // Pack bits and hold the output byte
    lsbpk_dp #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .st        (st),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- verif/lsb_first_bit_packer_gamma_writer_tb.sv -----
// Self-checking testbench for lsb_first_bit_packer_gamma_writer.
// Packs raw and gamma-coded requests in a local bit-accurate predictor and compares every byte.
// Depends on lsbpk_pkg for the request structs and opcodes.
`timescale 1ns / 1ps

module lsb_first_bit_packer_gamma_writer_tb;

    // Spare opcode that the block must ignore
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int STALL_LIMIT     = 3000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 64;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    lsbpk_pkg::in_req_t  in_data;
    logic                out_valid;
    logic                out_ready;
    lsbpk_pkg::out_req_t out_data;

    // Predictor state: bits waiting for a full byte, earliest in bit 0
    logic [7:0]          pend_acc;
    int                  pend_cnt;
    logic [7:0]          item_bytes[$];
    lsbpk_pkg::out_req_t expected_bytes[$];

    int  fail_count;
    int  src_idle_pct;
    int  sink_stall_pct;
    bit  hold_off_req;

    lsb_first_bit_packer_gamma_writer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Append one bit to the packed stream; emit the byte once eight bits are held
    function automatic void pack_bit(input logic b);
        pend_acc[pend_cnt] = b;
        pend_cnt++;
        if (pend_cnt == 8)
        begin
            item_bytes.push_back(pend_acc);
            pend_acc = '0;
            pend_cnt = 0;
        end
    endfunction

    // Compute the bytes one accepted request produces and queue them
    function automatic void pack_request(input lsbpk_pkg::in_req_t req);
        int                  n_bits;
        int                  top;
        lsbpk_pkg::out_req_t res;
        item_bytes.delete();
        case (req.opcode)
            lsbpk_pkg::OP_RAW:
            begin
                n_bits = (req.width > lsbpk_pkg::WORD_BITS_DEF) ? lsbpk_pkg::WORD_BITS_DEF
                                                                : int'(req.width);
                for (int k = 0; k < n_bits; k++)
                    pack_bit(req.value[k]);
            end
            lsbpk_pkg::OP_GAMMA:
            begin
                if (req.value == '0)
                    pack_bit(1'b0);
                else
                begin
                    top = 0;
                    for (int k = 0; k < 64; k++)
                        if (req.value[k])
                            top = k;
                    // Each data bit, msb first, followed by its stop bit
                    for (int k = top; k >= 0; k--)
                    begin
                        pack_bit(req.value[k]);
                        pack_bit(k == 0);
                    end
                end
            end
            lsbpk_pkg::OP_FINISH:
            begin
                if (pend_cnt != 0)
                begin
                    item_bytes.push_back(pend_acc);
                    pend_acc = '0;
                    pend_cnt = 0;
                end
            end
            default: ;
        endcase
        foreach (item_bytes[i])
        begin
            res.out_byte  = item_bytes[i];
            res.last_byte = (i == item_bytes.size() - 1);
            expected_bytes.push_back(res);
        end
    endfunction

    function automatic lsbpk_pkg::in_req_t make_req(input logic [1:0] op,
                                                    input logic [6:0] w,
                                                    input logic [63:0] v);
        lsbpk_pkg::in_req_t req;
        req.opcode = op;
        req.width  = w;
        req.value  = v;
        return req;
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly raw and gamma requests with random content, some finish and spare
    function automatic lsbpk_pkg::in_req_t random_request();
        int         pick;
        logic [6:0] w;
        logic [63:0] v;
        pick = $urandom_range(99);
        w = 7'($urandom_range(0, lsbpk_pkg::WORD_BITS_DEF));
        v = rand_word();
        if (pick < 42)
        begin
            if ($urandom_range(9) == 0)
                w = 7'($urandom_range(65, 127));
            return make_req(lsbpk_pkg::OP_RAW, w, v);
        end
        else if (pick < 80)
        begin
            if ($urandom_range(15) == 0)
                v = '0;
            return make_req(lsbpk_pkg::OP_GAMMA, w, v >> $urandom_range(0, 63));
        end
        else if (pick < 94)
            return make_req(lsbpk_pkg::OP_FINISH, w, v);
        return make_req(OP_SPARE, 7'($urandom_range(0, 127)), v);
    endfunction

    // Offer one request, idling first at the sender's rate; predict on acceptance
    task automatic send_request(input lsbpk_pkg::in_req_t req);
        @(negedge clk);
        if ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (!in_ready);
        pack_request(req);
    endtask

    // Drive the receiver: random stalls, or a long hold-off when asked
    initial
    begin : sink_drive
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Compare each accepted byte with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte: out_byte=%02h last_byte=%0b",
                         $time, out_data.out_byte, out_data.last_byte);
                fail_count++;
            end
            else
            begin
                if (out_data.out_byte !== expected_bytes[0].out_byte ||
                    out_data.last_byte !== expected_bytes[0].last_byte)
                begin
                    $display({"%0t: mismatch: expected out_byte=%02h last_byte=%0b, ",
                              "actual out_byte=%02h last_byte=%0b"},
                             $time, expected_bytes[0].out_byte, expected_bytes[0].last_byte,
                             out_data.out_byte, out_data.last_byte);
                    fail_count++;
                end
                void'(expected_bytes.pop_front());
            end
        end
    end

    // End the run when no request moves for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("lsb_first_bit_packer_gamma_writer regression: fail");
        $finish;
    end

    // Extremes of every field, each opcode and each special case
    task automatic test_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_request(make_req(lsbpk_pkg::OP_FINISH, 7'd0, 64'd0));
        send_request(make_req(lsbpk_pkg::OP_RAW, 7'd0, '1));
        send_request(make_req(lsbpk_pkg::OP_RAW, 7'd1, 64'd1));
        send_request(make_req(lsbpk_pkg::OP_RAW, 7'd7, 64'h55));
        send_request(make_req(lsbpk_pkg::OP_RAW, 7'd8, 64'hFF));
        send_request(make_req(lsbpk_pkg::OP_RAW, 7'd64, '1));
        send_request(make_req(lsbpk_pkg::OP_RAW, 7'd64, 64'd0));
        send_request(make_req(lsbpk_pkg::OP_RAW, 7'd3, 64'd5));
        send_request(make_req(lsbpk_pkg::OP_FINISH, 7'd0, 64'd0));
        send_request(make_req(lsbpk_pkg::OP_RAW, 7'd127, 64'hA5A5_5A5A_C3C3_3C3C));
        send_request(make_req(lsbpk_pkg::OP_RAW, 7'd65, 64'h0123_4567_89AB_CDEF));
        send_request(make_req(lsbpk_pkg::OP_GAMMA, 7'd0, 64'd0));
        send_request(make_req(lsbpk_pkg::OP_GAMMA, 7'd127, 64'd1));
        send_request(make_req(lsbpk_pkg::OP_GAMMA, 7'd0, 64'd2));
        send_request(make_req(lsbpk_pkg::OP_GAMMA, 7'd0, '1));
        send_request(make_req(lsbpk_pkg::OP_GAMMA, 7'd0, 64'h8000_0000_0000_0000));
        send_request(make_req(OP_SPARE, 7'd127, '1));
        send_request(make_req(lsbpk_pkg::OP_GAMMA, 7'd0, 64'h5555_5555_5555_5555));
        send_request(make_req(lsbpk_pkg::OP_RAW, 7'd5, 64'h1F));
        send_request(make_req(OP_SPARE, 7'd0, 64'd0));
        send_request(make_req(lsbpk_pkg::OP_FINISH, 7'd127, '1));
        send_request(make_req(lsbpk_pkg::OP_FINISH, 7'd0, 64'd0));
        send_request(make_req(lsbpk_pkg::OP_GAMMA, 7'd0, 64'd6));
        send_request(make_req(lsbpk_pkg::OP_RAW, 7'd64, rand_word()));
        send_request(make_req(lsbpk_pkg::OP_FINISH, 7'd0, 64'd0));
    endtask

    // Random requests under one idling pattern
    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (count) send_request(random_request());
    endtask

    // Hold the receiver off while long gamma requests keep coming, so the block backs up
    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_off_req   = 1'b1;
        repeat (14)
            send_request(make_req(lsbpk_pkg::OP_GAMMA, 7'd0,
                                  rand_word() | 64'h8000_0000_0000_0000));
        while (hold_off_req)
            @(posedge clk);
    endtask

    initial
    begin
        fail_count     = 0;
        pend_acc       = '0;
        pend_cnt       = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_off_req   = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(50, 0, 0);
        test_random(50, 87, 0);
        test_random(50, 0, 87);
        test_random(50, 9, 9);
        test_backpressure();

        // Drop valid and drain the outstanding bytes
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("lsb_first_bit_packer_gamma_writer regression: pass");
        else
            $display("lsb_first_bit_packer_gamma_writer regression: fail");
        $finish;
    end

endmodule
